@@ rtl/masked_signature_scanner_defines.svh @@
// Assertion macros for the signature scanner.
// Each check samples on the rising edge of clk and is off while rst_n is low.
`ifndef MASKED_SIGNATURE_SCANNER_DEFINES_SVH
`define MASKED_SIGNATURE_SCANNER_DEFINES_SVH

`ifndef SYNTHESIS
`define MSS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mss check failed");
`define MSS_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`else
`define MSS_ASSERT(lbl, prop)
`define MSS_ASSERT_MSG(lbl, prop, msg)
`endif

`endif

@@ rtl/mss_pkg.sv @@
`default_nettype none

package mss_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int SEEN_W          = 33;
    localparam int LEN_W           = 5;
    localparam int ADDR_W          = 32;
    localparam int CARE_W          = 16;
    localparam int PAT_W           = 128;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE    = 3'd4;

    localparam logic [CARE_W-1:0] CARE_RESET = 16'hFFFF;
    localparam logic [LEN_W-1:0]  LEN_RESET  = 5'd1;

    typedef struct packed {
        logic [PAT_W-1:0]  pattern;   // byte 0 in bits 7:0
        logic [CARE_W-1:0] care;
        logic [LEN_W-1:0]  used_len;  // already clamped to 1..MAX_PATTERN
        logic [ADDR_W-1:0] base;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       region_start;
        logic       region_end;
    } item_t;

    typedef struct packed {
        logic              active;    // beat is scanned, not ignored
        logic [SEEN_W-1:0] seen_new;  // byte count including this beat
    } view_t;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } res_t;

endpackage

`default_nettype wire

@@ rtl/mss_cfg_regs.sv @@
`default_nettype none

module mss_cfg_regs #(
    parameter int MAX_PATTERN = mss_pkg::MAX_PATTERN_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [mss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mss_pkg::CFG_DATA_W-1:0]   cfg_data,
    output mss_pkg::cfg_t                         cfg
);

    logic [63:0]                 pat_lo_reg;
    logic [63:0]                 pat_hi_reg;
    logic [mss_pkg::CARE_W-1:0]  care_reg;
    logic [mss_pkg::LEN_W-1:0]   len_reg;
    logic [mss_pkg::ADDR_W-1:0]  base_reg;
    logic [mss_pkg::LEN_W-1:0]   used_len;

    localparam logic [mss_pkg::LEN_W-1:0] LEN_MAX = mss_pkg::LEN_W'(MAX_PATTERN);

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lo_reg <= '0;
            pat_hi_reg <= '0;
            care_reg   <= mss_pkg::CARE_RESET;
            len_reg    <= mss_pkg::LEN_RESET;
            base_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mss_pkg::REG_PATTERN_LOW:    pat_lo_reg <= cfg_data;
                mss_pkg::REG_PATTERN_HIGH:   pat_hi_reg <= cfg_data;
                mss_pkg::REG_CARE_MASK:      care_reg   <= cfg_data[mss_pkg::CARE_W-1:0];
                mss_pkg::REG_PATTERN_LENGTH: len_reg    <= cfg_data[mss_pkg::LEN_W-1:0];
                mss_pkg::REG_REGION_BASE:    base_reg   <= cfg_data[mss_pkg::ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    // zero acts as one, anything past the window depth as the depth
    always_comb
    begin
        if (len_reg == '0)
            used_len = mss_pkg::LEN_W'(1);
        else if (len_reg > LEN_MAX)
            used_len = LEN_MAX;
        else
            used_len = len_reg;
    end

    assign cfg.pattern  = {pat_hi_reg, pat_lo_reg};
    assign cfg.care     = care_reg;
    assign cfg.used_len = used_len;
    assign cfg.base     = base_reg;

endmodule

`default_nettype wire

@@ rtl/mss_track.sv @@
`default_nettype none

`include "masked_signature_scanner_defines.svh"

module mss_track #(
    parameter int MAX_PATTERN = mss_pkg::MAX_PATTERN_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        acc,
    input  wire mss_pkg::item_t              item,
    input  wire logic                        emit,
    output mss_pkg::view_t                   view,
    output logic [MAX_PATTERN-1:0][7:0]      win_new
);

    localparam int SW = mss_pkg::SEEN_W;

    logic [MAX_PATTERN-1:0][7:0] win_reg;
    logic [SW-1:0]               seen_reg;
    logic [SW-1:0]               seen_base;
    logic [SW-1:0]               seen_next;
    logic                        fin_reg;
    logic                        fin_base;
    logic                        fin_next;

    // a region start wipes the count and the finished flag before the beat
    assign seen_base = item.region_start ? '0 : seen_reg;
    assign fin_base  = item.region_start ? 1'b0 : fin_reg;

    always_comb
    begin
        view.active   = !fin_base;
        view.seen_new = (seen_base == {SW{1'b1}}) ? seen_base : seen_base + SW'(1);
        win_new[0]    = item.data_byte;
        for (int k = 1; k < MAX_PATTERN; k++)
            win_new[k] = win_reg[k-1];
    end

    assign seen_next = view.active ? view.seen_new : seen_base;
    assign fin_next  = fin_base | emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            fin_reg  <= 1'b0;
        end
        else if (acc)
        begin
            seen_reg <= seen_next;
            fin_reg  <= fin_next;
        end
    end

    // window entries older than the count are never compared, so no clear
    always_ff @(posedge clk)
    begin
        if (acc && view.active)
            win_reg <= win_new;
    end

    `MSS_ASSERT_MSG(a_ignored_beat_holds_count,
        acc && !item.region_start && fin_reg |=> $stable(seen_reg),
        "count moved on an ignored beat")
    `MSS_ASSERT(a_emit_only_when_active, emit |-> view.active)

endmodule

`default_nettype wire

@@ rtl/mss_match.sv @@
`default_nettype none

module mss_match #(
    parameter int MAX_PATTERN = mss_pkg::MAX_PATTERN_DEF
) (
    input  wire mss_pkg::cfg_t               cfg,
    input  wire mss_pkg::view_t              view,
    input  wire logic [MAX_PATTERN-1:0][7:0] win_new,
    input  wire logic                        region_end,
    output logic                             emit,
    output mss_pkg::res_t                    res
);

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LW    = mss_pkg::LEN_W;

    logic [LW-1:0]          pos [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] lane_ok;
    logic                   long_enough;
    logic                   hit;

    // signature byte i lines up with window entry used_len-1-i (newest at 0)
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            pos[i]     = cfg.used_len - LW'(i) - LW'(1);
            lane_ok[i] = !((LW'(i) < cfg.used_len) && cfg.care[i])
                         || (cfg.pattern[8*i +: 8] == win_new[pos[i][IDX_W-1:0]]);
        end
    end

    assign long_enough = view.seen_new >= {{(mss_pkg::SEEN_W-LW){1'b0}}, cfg.used_len};
    assign hit  = view.active && long_enough && (&lane_ok);
    assign emit = hit || (view.active && region_end);

    assign res.found         = hit;
    assign res.match_address = hit
        ? cfg.base + view.seen_new[mss_pkg::ADDR_W-1:0]
          - {{(mss_pkg::ADDR_W-LW){1'b0}}, cfg.used_len}
        : '0;

endmodule

`default_nettype wire

@@ rtl/mss_out_buf.sv @@
`default_nettype none

`include "masked_signature_scanner_defines.svh"

module mss_out_buf (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire mss_pkg::res_t res_in,
    output logic         full,
    output logic         out_valid,
    input  wire logic    out_stall,
    output mss_pkg::res_t res_out
);

    logic          out_valid_reg;
    logic          skid_valid_reg;
    mss_pkg::res_t out_reg;
    mss_pkg::res_t skid_reg;
    logic          pop;

    assign pop       = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign res_out   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            if (!out_valid_reg || pop)
                out_reg <= res_in;
            else
                skid_reg <= res_in;
        end
        else if (pop && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    `MSS_ASSERT(a_skid_needs_head, skid_valid_reg |-> out_valid_reg)
    `MSS_ASSERT_MSG(a_no_push_when_full, push |-> !skid_valid_reg,
        "result pushed into a full buffer")
    `MSS_ASSERT(a_skid_fills_on_stall, $rose(skid_valid_reg) |-> $past(out_stall))

endmodule

`default_nettype wire

@@ rtl/masked_signature_scanner.sv @@
// Masked byte signature scanner.
// Input channel (in_valid / in_stall): one byte of a memory region per beat,
// in address order, with region_start on the first byte and region_end on the
// last. A beat moves when in_valid is high and in_stall is low.
// Output channel (out_valid / out_stall): one result per region, found=1 with
// match_address = region_base + offset of the first match, or found=0 and
// address 0 on the region's last byte. Beats after the result are dropped
// until the next region_start.
// Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): registers
// 0 pattern_low, 1 pattern_high, 2 care_mask, 3 pattern_length, 4 region_base;
// write only while the scanner is idle. cfg_ready is always high.
// Throughput: one byte per cycle while not stalled, set by the parallel
// compare of the 16-byte shift window. Latency: with the output buffer empty,
// the result appears on out_valid the cycle after the byte that completes it
// is accepted. Stall: a two-entry output buffer holds results; in_stall rises
// only once both entries are full and drops as soon as one is taken.
// Reset (rst_n, async low): registers return to their defaults, the byte
// count and finished flag clear, and the output buffer empties.
`default_nettype none

module masked_signature_scanner #(
    parameter int MAX_PATTERN = mss_pkg::MAX_PATTERN_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [7:0]                     data_byte,
    input  wire logic                           region_start,
    input  wire logic                           region_end,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                found,
    output logic [mss_pkg::ADDR_W-1:0]          match_address,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [mss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mss_pkg::CFG_DATA_W-1:0] cfg_data
);

    mss_pkg::cfg_t               cfg;
    mss_pkg::item_t              item;
    mss_pkg::view_t              view;
    mss_pkg::res_t               res_new;
    mss_pkg::res_t               res_out;
    logic [MAX_PATTERN-1:0][7:0] win_new;
    logic                        acc;
    logic                        emit;
    logic                        buf_full;

    assign item.data_byte    = data_byte;
    assign item.region_start = region_start;
    assign item.region_end   = region_end;

    // accept a beat whenever the output buffer has a free entry
    assign in_stall = buf_full;
    assign acc      = in_valid && !in_stall;

    mss_cfg_regs #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // window, saturating byte count, finished flag
    mss_track #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_track (
        .clk     (clk),
        .rst_n   (rst_n),
        .acc     (acc),
        .item    (item),
        .emit    (emit),
        .view    (view),
        .win_new (win_new)
    );

    // parallel masked compare and address
    mss_match #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_match (
        .cfg        (cfg),
        .view       (view),
        .win_new    (win_new),
        .region_end (region_end),
        .emit       (emit),
        .res        (res_new)
    );

    mss_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (acc && emit),
        .res_in    (res_new),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_out   (res_out)
    );

    assign found         = res_out.found;
    assign match_address = res_out.match_address;

endmodule

`default_nettype wire
